FILE: design/ccfp_pkg.sv
// Shared constants, types and the CRC-8 fold for the CRSF channel frame parser.
package ccfp_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PosW        = 9;
  localparam int unsigned ChanW       = 11;
  localparam int unsigned ChanCount   = 16;
  localparam int unsigned ChanIdxW    = $clog2(ChanCount);
  localparam int unsigned PayloadLen  = 22;
  localparam int unsigned PayloadW    = PayloadLen * ByteW;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  localparam logic [ByteW-1:0] SyncReset     = 8'hC8;
  localparam logic [ByteW-1:0] CheckedLength = 8'd24;
  localparam logic [ByteW-1:0] CrcPoly       = 8'hD5;
  localparam logic [PosW-1:0]  PosHunt       = 9'd0;
  localparam logic [PosW-1:0]  PosLength     = 9'd1;
  localparam logic [PosW-1:0]  PosFirstBody  = 9'd2;
  localparam logic [PosW-1:0]  PosFirstPl    = 9'd3;
  localparam logic [PosW-1:0]  PosLastPl     = 9'd24;

  // One finished length-24 frame handed from the parser to the emitter
  typedef struct packed {
    logic                crc_error;
    logic [PayloadW-1:0] payload;
  } frame_cmd_t;

  // Fold one byte into the CRC, MSB first
  function automatic logic [ByteW-1:0] crc_fold(input logic [ByteW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      if (v[ByteW-1]) begin
        v = (v << 1) ^ CrcPoly;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

endpackage

FILE: design/crsf_in_if.sv
// Byte input channel: valid/ready handshake with one received byte per beat.
interface crsf_in_if;
  import ccfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/crsf_out_if.sv
// Result channel: valid/ready handshake with one channel value per beat.
interface crsf_out_if;
  import ccfp_pkg::*;

  logic                valid;
  logic                ready;
  logic [ChanIdxW-1:0] channel_index;
  logic [ChanW-1:0]    channel_value;
  logic                crc_error;
  logic                last;

  modport source (output valid, output channel_index, output channel_value,
                  output crc_error, output last, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input crc_error, input last, output ready);
endinterface

FILE: design/ccfp_front.sv
// Front end: sync hunt, length tracking, CRC accumulation and payload capture.
module ccfp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  crsf_in_if.sink                in_ch,
  input  logic                   q_full_i,
  output logic                   push_o,
  output ccfp_pkg::frame_cmd_t   push_cmd_o
);
  import ccfp_pkg::*;

  logic [ByteW-1:0]    sync_q;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [ByteW-1:0]    len_q, len_d;
  logic [ByteW-1:0]    crc_q, crc_d;
  logic [PayloadW-1:0] pl_q;
  logic [PosW-1:0]     crc_pos;
  logic                in_body;
  logic                at_crc;
  logic                accept;
  logic                pl_shift;
  logic [ByteW-1:0]    b;

  assign b       = in_ch.rx_byte;
  assign crc_pos = {1'b0, len_q} + PosLength;
  assign in_body = (pos_q >= PosFirstBody) && (pos_q < crc_pos);
  assign at_crc  = (pos_q >= PosFirstBody) && !in_body;

  // Stall only on a checked frame's CRC byte while the queue has no room
  assign in_ch.ready = !(at_crc && (len_q == CheckedLength) && q_full_i);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pl_shift    = accept && in_body && (pos_q >= PosFirstPl) && (pos_q <= PosLastPl);

  // Advance the frame position, length and CRC
  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    crc_d = crc_q;
    if (accept) begin
      if (pos_q == PosHunt) begin
        if (b == sync_q) pos_d = PosLength;
      end else if (pos_q == PosLength) begin
        len_d = b;
        crc_d = '0;
        pos_d = (b == '0) ? PosHunt : PosFirstBody;
      end else if (in_body) begin
        crc_d = crc_fold(crc_q, b);
        pos_d = pos_q + PosLength;
      end else begin
        pos_d = PosHunt;
      end
    end
  end

  assign push_o               = accept && at_crc && (len_q == CheckedLength);
  assign push_cmd_o.crc_error = (b != crc_q);
  assign push_cmd_o.payload   = pl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
      pos_q  <= PosHunt;
      len_q  <= '0;
      crc_q  <= '0;
    end else begin
      if (cfg_we_i) sync_q <= cfg_wdata_i;
      pos_q <= pos_d;
      len_q <= len_d;
      crc_q <= crc_d;
    end
  end

  // Shift payload bytes in at the top; the first lands in the low byte
  always_ff @(posedge clk_i) begin
    if (pl_shift) pl_q <= {b, pl_q[PayloadW-1:ByteW]};
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i) else $error("push into full queue");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= ({1'b0, len_q} + PosLength) || pos_q == PosLength)
    else $error("frame position past CRC byte");
  a_hunt_after_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && at_crc) |=> pos_q == PosHunt) else $error("no return to hunt");
endmodule

FILE: design/ccfp_queue.sv
// Two-entry queue of finished frames between the parser and the emitter.
module ccfp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ccfp_pkg::frame_cmd_t push_cmd_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output ccfp_pkg::frame_cmd_t head_o
);
  import ccfp_pkg::*;

  frame_cmd_t           entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Hold the frame data
  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth)) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QueueCntW'(QueueDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");
endmodule

FILE: design/ccfp_back.sv
// Back end: unpack a queued frame into channel beats through an output register.
module ccfp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  ccfp_pkg::frame_cmd_t head_i,
  output logic                 pop_o,
  crsf_out_if.source           out_ch
);
  import ccfp_pkg::*;

  logic                active_q;
  logic                err_q;
  logic [PayloadW-1:0] sr_q;
  logic [ChanIdxW-1:0] idx_q;
  logic                ov_q;
  logic [ChanIdxW-1:0] o_idx_q;
  logic [ChanW-1:0]    o_val_q;
  logic                o_err_q;
  logic                o_last_q;
  logic                advance;
  logic                is_last;

  assign pop_o   = !active_q && !q_empty_i;
  assign advance = active_q && (!ov_q || out_ch.ready);
  assign is_last = err_q || (idx_q == ChanIdxW'(ChanCount - 1));

  // Load a frame, then step through its channels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (pop_o) active_q <= 1'b1;
      else if (advance && is_last) active_q <= 1'b0;
      if (advance) ov_q <= 1'b1;
      else if (out_ch.ready) ov_q <= 1'b0;
    end
  end

  // Hold the working payload and the output beat
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sr_q  <= head_i.payload;
      err_q <= head_i.crc_error;
      idx_q <= '0;
    end else if (advance) begin
      sr_q  <= sr_q >> ChanW;
      idx_q <= idx_q + 1'b1;
    end
    if (advance) begin
      o_idx_q  <= err_q ? '0 : idx_q;
      o_val_q  <= err_q ? '0 : sr_q[ChanW-1:0];
      o_err_q  <= err_q;
      o_last_q <= is_last;
    end
  end

  assign out_ch.valid         = ov_q;
  assign out_ch.channel_index = o_idx_q;
  assign out_ch.channel_value = o_val_q;
  assign out_ch.crc_error     = o_err_q;
  assign out_ch.last          = o_last_q;

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_err_q) |-> (o_last_q && o_idx_q == '0 && o_val_q == '0))
    else $error("error beat malformed");
  a_last_ch15: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !o_err_q && o_last_q) |-> o_idx_q == ChanIdxW'(ChanCount - 1))
    else $error("last beat not on final channel");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !active_q) else $error("load while emitting");
endmodule

FILE: design/crsf_channel_frame_parser.sv
// Top level of the CRSF RC-channels frame parser.
//
// Usage: bytes from the serial receiver enter on in_ch, one byte per beat.
// The parser hunts for the sync address (cfg register, reset 0xC8), reads
// the length byte, folds the body into a CRC-8 (poly 0xD5) and checks the
// CRC byte of length-24 frames. A good frame yields 16 beats on out_ch
// (channels 0..15, last on channel 15); a bad CRC yields one error beat.
// Other lengths are consumed without output.
// With the emitter idle, a frame passes the queue entry, the emitter's
// working register and its output register before its first beat is valid;
// beats follow one per cycle while out_ch is ready, and a queued frame loads
// once the previous frame's last beat has entered the output register.
// Bytes are taken one per cycle while in_ch.ready is high. A two-entry frame
// queue separates the parser from the emitter; in_ch.ready drops only on the
// CRC byte of a length-24 frame while that queue is full, which happens only
// when out_ch stalls. Beats held on out_ch stay stable until taken.
// Reset: asynchronous, active low; the parser returns to hunting, the
// queue empties and the sync address returns to 0xC8.
module crsf_channel_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  crsf_in_if.sink    in_ch,
  crsf_out_if.source out_ch
);
  import ccfp_pkg::*;

  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  frame_cmd_t push_cmd;
  frame_cmd_t head;

  ccfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  ccfp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (q_full),
    .empty_o   (q_empty),
    .pop_i     (pop),
    .head_o    (head)
  );

  ccfp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .head_i   (head),
    .pop_o    (pop),
    .out_ch   (out_ch)
  );
endmodule

FILE: test/crsf_channel_frame_parser_tb.sv
// Self-checking testbench for the CRSF channel frame parser: byte stream in, channel beats out.
module crsf_channel_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfp_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 24;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         PHASE_BYTES  = 10;
  localparam int         PLAN_ROWS    = 11;
  localparam logic [7:0] TYPE_RC      = 8'h16;

  typedef enum logic [1:0] {ROW_BYTE, ROW_FRAME} row_e;
  typedef enum logic [2:0] {FILL_ZERO, FILL_ONES, FILL_ALT, FILL_SYNC, FILL_RAND} fill_e;
  typedef enum logic [2:0] {WANT_MODEL, WANT_NONE, WANT_ERROR, WANT_ZEROS, WANT_ONES} want_e;

  // One directed row: a lone byte, or a whole frame built from a fill pattern
  typedef struct packed {
    row_e       kind;
    logic [7:0] head;
    logic [7:0] len;
    fill_e      fill;
    logic [7:0] flip;
    want_e      want;
  } plan_row_t;

  typedef struct packed {
    logic [ChanIdxW-1:0] chan;
    logic [ChanW-1:0]    value;
    logic                crc_bad;
    logic                last;
  } chan_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  crsf_in_if  in_ch ();
  crsf_out_if out_ch ();

  crsf_channel_frame_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Parser shadow state
  logic [7:0]    sync_addr;
  logic [PosW-1:0] hunt_pos;
  logic [7:0]    len_seen;
  logic [7:0]    crc_run;
  logic [7:0]    payload_seen [PayloadLen];
  chan_beat_t    beats_due [$];

  logic hold_go   = 1'b0;
  logic hold_off;
  logic quiet     = 1'b0;
  logic use_model = 1'b1;
  int   mismatches, bytes_sent, beats_seen, error_beats, in_stalls, cycles;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_BYTE,  8'h00,     8'd0,          FILL_ZERO, 8'h00, WANT_NONE},
    '{ROW_BYTE,  8'hFF,     8'd0,          FILL_ZERO, 8'h00, WANT_NONE},
    '{ROW_FRAME, SyncReset, CheckedLength, FILL_ZERO, 8'h00, WANT_ZEROS},
    '{ROW_FRAME, SyncReset, CheckedLength, FILL_ONES, 8'h00, WANT_ONES},
    '{ROW_FRAME, SyncReset, CheckedLength, FILL_RAND, 8'h01, WANT_ERROR},
    '{ROW_FRAME, SyncReset, 8'd0,          FILL_ZERO, 8'h00, WANT_NONE},
    '{ROW_FRAME, SyncReset, 8'd1,          FILL_ZERO, 8'h3C, WANT_NONE},
    '{ROW_FRAME, SyncReset, 8'd23,         FILL_RAND, 8'h00, WANT_NONE},
    '{ROW_FRAME, SyncReset, 8'd25,         FILL_RAND, 8'h5A, WANT_NONE},
    '{ROW_FRAME, SyncReset, CheckedLength, FILL_SYNC, 8'h00, WANT_MODEL},
    '{ROW_FRAME, SyncReset, 8'd2,          FILL_RAND, 8'h00, WANT_NONE}
  };

  // CRC-8, polynomial 0xD5, one data bit at a time, MSB first
  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[7] ^ data[k];
      c  = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 30) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  // Advance the shadow parser by one byte and queue the beats it yields
  task automatic parse_byte(input logic [7:0] b);
    logic [PayloadW-1:0] flat;
    if (hunt_pos == PosHunt) begin
      if (b == sync_addr) hunt_pos = PosLength;
    end else if (hunt_pos == PosLength) begin
      len_seen = b;
      crc_run  = 8'h00;
      hunt_pos = (b == 8'h00) ? PosHunt : PosFirstBody;
    end else if (int'(hunt_pos) < int'(len_seen) + 1) begin
      crc_run = crc8_d5(crc_run, b);
      if (hunt_pos >= PosFirstPl && hunt_pos <= PosLastPl) begin
        payload_seen[hunt_pos - PosFirstPl] = b;
      end
      hunt_pos++;
    end else begin
      // CRC byte: only length-24 frames report anything
      hunt_pos = PosHunt;
      if (len_seen == CheckedLength && use_model) begin
        if (b != crc_run) begin
          beats_due.push_back('{'0, '0, 1'b1, 1'b1});
        end else begin
          for (int i = 0; i < PayloadLen; i++) flat[i*ByteW +: ByteW] = payload_seen[i];
          for (int ch = 0; ch < ChanCount; ch++) begin
            beats_due.push_back('{ChanIdxW'(ch), flat[ch*ChanW +: ChanW], 1'b0,
                                  ch == ChanCount - 1});
          end
        end
      end
    end
  endtask

  // Offer one byte, with an occasional gap before it, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    parse_byte(b);
    bytes_sent++;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  // Build address, length, body and CRC; flip corrupts the CRC byte
  task automatic send_frame(input logic [7:0] addr, input int len, input fill_e fill,
                            input logic [7:0] flip);
    logic [7:0] body [$];
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < len - 1; i++) begin
      if (i == 0) begin
        body.push_back(fill == FILL_RAND ? 8'($urandom_range(0, 255)) : TYPE_RC);
      end else begin
        case (fill)
          FILL_ZERO: body.push_back(8'h00);
          FILL_ONES: body.push_back(8'hFF);
          FILL_ALT:  body.push_back(i[0] ? 8'h55 : 8'hAA);
          FILL_SYNC: body.push_back(addr);
          default:   body.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      crc = crc8_d5(crc, body[i]);
    end
    send_byte(addr);
    send_byte(8'(len));
    if (len != 0) begin
      foreach (body[i]) send_byte(body[i]);
      send_byte(crc ^ flip);
    end
  endtask

  // Mostly well-formed frames, plus corrupted CRCs, noise and frames cut short
  task automatic random_traffic(input int budget);
    int spent, pick, len;
    spent = 0;
    while (spent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(sync_addr, CheckedLength, FILL_RAND, 8'h00);
        spent += 26;
      end else if (pick < 70) begin
        send_frame(sync_addr, CheckedLength, FILL_RAND, 8'($urandom_range(1, 255)));
        spent += 26;
      end else if (pick < 85) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 30);
        send_frame(sync_addr, len, FILL_RAND, 8'h00);
        spent += len + 2;
      end else if (pick < 93) begin
        len = $urandom_range(1, 4);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        spent += len;
      end else begin
        len = $urandom_range(0, 22);
        send_byte(sync_addr);
        send_byte(CheckedLength);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        spent += len + 2;
      end
    end
  endtask

  // Finish any open frame, drop valid, and wait for the result side to drain
  task automatic settle();
    while (hunt_pos != PosHunt) send_byte(8'h00);
    in_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] addr);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    sync_addr = addr;
  endtask

  // Compare one taken beat against the oldest expectation
  task automatic take_beat();
    chan_beat_t want;
    if (beats_due.size() == 0) begin
      note_mismatch($sformatf("beat with nothing expected: ch %0d value %0d err %0b last %0b",
                              out_ch.channel_index, out_ch.channel_value,
                              out_ch.crc_error, out_ch.last));
      return;
    end
    want = beats_due.pop_front();
    if (out_ch.channel_index !== want.chan) begin
      note_mismatch($sformatf("channel_index %0d, want %0d", out_ch.channel_index, want.chan));
    end
    if (out_ch.channel_value !== want.value) begin
      note_mismatch($sformatf("channel_value %0d on ch %0d, want %0d",
                              out_ch.channel_value, want.chan, want.value));
    end
    if (out_ch.crc_error !== want.crc_bad) begin
      note_mismatch($sformatf("crc_error %0b, want %0b", out_ch.crc_error, want.crc_bad));
    end
    if (out_ch.last !== want.last) begin
      note_mismatch($sformatf("last %0b on ch %0d, want %0b", out_ch.last, want.chan,
                              want.last));
    end
    beats_seen++;
    if (want.crc_bad) error_beats++;
  endtask

  // Result side: check taken beats, then pick ready for the next edge
  initial begin : sink_side
    int gap_left;
    gap_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) take_beat();
      if (hold_off || gap_left > 0) begin
        out_ch.ready <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        gap_left = $urandom_range(0, 12);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Long hold-off on the result side, once, so the frame queue fills up
  initial begin : hold_side
    hold_off <= 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Cycle limit; also count cycles where the input is pushed back
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b0) in_stalls++;
    end
    $display("crsf_channel_frame_parser: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] sync_plan [4];
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 8'h00;
    sync_addr = SyncReset;
    hunt_pos  = PosHunt;
    len_seen  = 8'h00;
    crc_run   = 8'h00;
    sync_plan = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), SyncReset};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset address; typed rows bypass the shadow parser
    foreach (plan[r]) begin
      use_model = (plan[r].want == WANT_MODEL);
      case (plan[r].want)
        WANT_ERROR: beats_due.push_back('{'0, '0, 1'b1, 1'b1});
        WANT_ZEROS, WANT_ONES: begin
          for (int ch = 0; ch < ChanCount; ch++) begin
            beats_due.push_back('{ChanIdxW'(ch), {ChanW{plan[r].want == WANT_ONES}}, 1'b0,
                                  ch == ChanCount - 1});
          end
        end
        default: ;
      endcase
      if (plan[r].kind == ROW_BYTE) begin
        send_byte(plan[r].head);
      end else begin
        send_frame(plan[r].head, int'(plan[r].len), plan[r].fill, plan[r].flip);
      end
    end
    use_model = 1'b1;

    // Random traffic under each sync address; the last phase runs without gaps
    for (int p = 0; p < 4; p++) begin
      settle();
      write_sync(sync_plan[p]);
      if (p == 3) quiet <= 1'b1;
      if (p == 0) begin
        hold_go = 1'b1;
        repeat (4) send_frame(sync_addr, CheckedLength, FILL_RAND, 8'h00);
      end
      random_traffic(PHASE_BYTES);
    end
    settle();

    $display("%0d bytes: directed rows at the reset sync address, then random frames",
             bytes_sent);
    $display("under four written addresses; %0d beats checked, %0d crc errors, %0d input stalls",
             beats_seen, error_beats, in_stalls);
    if (mismatches == 0) begin
      $display("crsf_channel_frame_parser: match");
    end else begin
      $display("crsf_channel_frame_parser: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ccfp_pkg.sv
design/crsf_in_if.sv
design/crsf_out_if.sv
design/ccfp_front.sv
design/ccfp_queue.sv
design/ccfp_back.sv
design/crsf_channel_frame_parser.sv
test/crsf_channel_frame_parser_tb.sv
